// ===== src/color_temperature_to_rgb_unit_macros.svh =====
// ----------------------------------------------------------------------------
// color_temperature_to_rgb_unit_macros
// assertion shorthands used by the checker file of the color unit
// ----------------------------------------------------------------------------
`ifndef COLOR_TEMPERATURE_TO_RGB_UNIT_MACROS_SVH
`define COLOR_TEMPERATURE_TO_RGB_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define CTR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define CTR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ctr_pkg.sv =====
// ----------------------------------------------------------------------------
// ctr_pkg
// widths, fixed-point constants and latencies of the color temperature unit
// ----------------------------------------------------------------------------
package ctr_pkg;

    // fixed-point formats
    localparam int FRAC_W  = 30;   // Q30 fraction bits
    localparam int X_W     = 25;   // Q16 argument of the log unit (t up to 400)
    localparam int M_W     = 31;   // normalized mantissa in [1,2) Q30
    localparam int IP_W    = 4;    // integer part of log2 (0..8)
    localparam int LOG_W   = IP_W + FRAC_W;
    localparam int LN_W    = 33;
    localparam int COEF_W  = 25;
    localparam int U_W     = 31;
    localparam int SUM_W   = 32;
    localparam int Q_W     = 31;
    localparam int REM_W   = 33;
    localparam int POW_W   = 26;
    localparam int LAW_W   = 28;   // signed channel value, Q16 on 0..255 scale
    localparam int EXP_TERMS = 16;

    localparam logic [63:0] ONE16 = 64'd1 << 16;
    localparam logic [63:0] ONE30 = 64'd1 << 30;

    // decimal constants given with ten fraction digits, rounded to Qk
    localparam logic [63:0] LN2_Q30 =
        (64'd6931471806 * (64'd1 << 30) + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] RED_C_Q16 =
        (64'd3296987274460 * (64'd1 << 16) + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] RED_P_Q30 =
        (64'd1332047592 * (64'd1 << 30) + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] GRN_A_Q16 =
        (64'd994708025861 * (64'd1 << 16) + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] GRN_B_Q16 =
        (64'd1611195681661 * (64'd1 << 16) + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] GRN_C_Q16 =
        (64'd2881221695283 * (64'd1 << 16) + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] GRN_P_Q30 =
        (64'd755148492 * (64'd1 << 30) + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] BLU_A_Q16 =
        (64'd1385177312231 * (64'd1 << 16) + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] BLU_B_Q16 =
        (64'd3050447927307 * (64'd1 << 16) + 64'd5000000000) / 64'd10000000000;

    // kelvin limits and decision points
    localparam logic [15:0] K_MIN     = 16'd1000;
    localparam logic [15:0] K_MAX     = 16'd40000;
    localparam logic [15:0] K_KNEE    = 16'd6600;
    localparam logic [15:0] K_BLU_OFF = 16'd1900;

    // t = (k*65536 + 50) / 100 through a reciprocal, exact below 2^32
    localparam int          T_DIV_SH  = 38;
    localparam logic [63:0] T_DIV_MAG = ((64'd1 << T_DIV_SH) + 64'd99) / 64'd100;

    // offsets of the fit in Q16
    localparam logic [X_W-1:0] T_OFS_RG = X_W'(60 * 65536);
    localparam logic [X_W-1:0] T_OFS_B  = X_W'(10 * 65536);

    // full scale of a channel value, 255.0 in Q16
    localparam logic [23:0] V_FULL    = 24'(255 * 65536);
    localparam logic [23:0] V_HALF    = 24'(255 * 32768);
    localparam int          LVL_SH    = 32;
    localparam logic [63:0] LVL_MAG   = ((64'd1 << LVL_SH) + 64'd254) / 64'd255;

    // pipeline depths
    localparam int IN_LAT    = 1;
    localparam int LOG2_LAT  = 1 + FRAC_W;
    localparam int POW_LAT   = 2 + 2 * EXP_TERMS + (Q_W) + 1;
    localparam int LAW_LAT   = 2;
    localparam int LVL_LAT   = 2;
    localparam int LAW_DLY   = POW_LAT - LAW_LAT;
    localparam int FLG_DEPTH = IN_LAT + LOG2_LAT + POW_LAT;
    localparam int TOTAL_LAT = FLG_DEPTH + LVL_LAT;

    // per-item range decisions that ride along the pipeline
    typedef struct packed {
        logic low;     // k at or below the knee
        logic bfull;   // blue saturated
        logic bzero;   // blue off
    } ctr_flags_t;

endpackage

// ===== src/ctr_log2.sv =====
// ----------------------------------------------------------------------------
// ctr_log2
// pipelined log2 of a Q16 value, one squaring step per stage, Q30 result
// ----------------------------------------------------------------------------
module ctr_log2 import ctr_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [X_W-1:0]   x,
    output logic [LOG_W-1:0] log_val
);

    logic [M_W-1:0]    m_reg  [0:FRAC_W];
    logic [IP_W-1:0]   ip_reg [0:FRAC_W];
    logic [FRAC_W-1:0] fr_reg [0:FRAC_W];

    logic [X_W-1:0]    x_clamp;
    logic [4:0]        msb;
    logic [M_W-1:0]    m_next;

    // clamp to one and normalize to [1,2)
    always_comb
    begin
        x_clamp = (x < X_W'(ONE16)) ? X_W'(ONE16) : x;
        msb     = 5'd16;
        for (int i = 16; i < X_W; i++)
        begin
            if (x_clamp[i])
                msb = 5'(i);
        end
        m_next = M_W'(x_clamp) << (5'd30 - msb);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0]  <= m_next;
            ip_reg[0] <= IP_W'(msb - 5'd16);
            fr_reg[0] <= '0;
        end
    end

    // one fraction bit per stage
    for (genvar j = 1; j <= FRAC_W; j++)
    begin : g_sq
        logic [2*M_W-1:0] sq;
        logic [31:0]      sq_s;

        always_comb
        begin
            sq   = (2*M_W)'(m_reg[j-1]) * (2*M_W)'(m_reg[j-1]);
            sq_s = sq[61:30];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ip_reg[j] <= ip_reg[j-1];
                if (sq_s[31])
                begin
                    m_reg[j]  <= sq_s[31:1];
                    fr_reg[j] <= fr_reg[j-1] | (FRAC_W'(1) << (FRAC_W - j));
                end
                else
                begin
                    m_reg[j]  <= sq_s[30:0];
                    fr_reg[j] <= fr_reg[j-1];
                end
            end
        end
    end

    assign log_val = {ip_reg[FRAC_W], fr_reg[FRAC_W]};

endmodule

// ===== src/ctr_pow.sv =====
// ----------------------------------------------------------------------------
// ctr_pow
// pipelined c * x^(-p) from log2(x): exponential series, reciprocal, scale
// ----------------------------------------------------------------------------
module ctr_pow import ctr_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [LOG_W-1:0]  log_val,
    input  logic [COEF_W-1:0] c_coef,
    input  logic [FRAC_W-1:0] p_coef,
    output logic [POW_W-1:0]  pow_val
);

    logic [LOG_W-1:0] z_reg;
    logic [U_W-1:0]   u_reg;
    logic [63:0]      z_prod;
    logic [63:0]      u_prod;

    // exponent scaled to natural log
    always_comb
    begin
        z_prod = 64'(p_coef) * 64'(log_val);
        u_prod = 64'(z_reg) * LN2_Q30;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg <= z_prod[30 +: LOG_W];
            u_reg <= u_prod[30 +: U_W];
        end
    end

    // series terms: multiply stage then divide-by-k stage
    logic [U_W-1:0]   tp_reg [0:EXP_TERMS-1];
    logic [U_W-1:0]   us_reg [0:EXP_TERMS-1];
    logic [SUM_W-1:0] sm_reg [0:EXP_TERMS-1];
    logic [U_W-1:0]   tm_reg [0:EXP_TERMS-1];
    logic [U_W-1:0]   ud_reg [0:EXP_TERMS-1];
    logic [SUM_W-1:0] sd_reg [0:EXP_TERMS-1];

    for (genvar j = 0; j < EXP_TERMS; j++)
    begin : g_term
        localparam int          K   = j + 1;
        localparam int          SH  = 31 + $clog2(K);
        localparam logic [63:0] MAG = ((64'd1 << SH) + 64'(K) - 64'd1) / 64'(K);

        logic [U_W-1:0]   term_in;
        logic [U_W-1:0]   u_in;
        logic [SUM_W-1:0] sum_in;
        logic [63:0]      mul;
        logic [63:0]      quo;

        always_comb
        begin
            if (j == 0)
            begin
                term_in = U_W'(ONE30);
                u_in    = u_reg;
                sum_in  = SUM_W'(ONE30);
            end
            else
            begin
                term_in = tm_reg[(j == 0) ? 0 : j-1];
                u_in    = ud_reg[(j == 0) ? 0 : j-1];
                sum_in  = sd_reg[(j == 0) ? 0 : j-1];
            end
            mul = 64'(term_in) * 64'(u_in);
            quo = (64'(tp_reg[j]) * MAG) >> SH;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tp_reg[j] <= mul[30 +: U_W];
                us_reg[j] <= u_in;
                sm_reg[j] <= sum_in;
                tm_reg[j] <= quo[U_W-1:0];
                ud_reg[j] <= us_reg[j];
                sd_reg[j] <= sm_reg[j] + SUM_W'(quo[U_W-1:0]);
            end
        end
    end

    // restoring division of 2^60 by the series sum, one quotient bit a stage
    logic [SUM_W-1:0] dv_reg [0:Q_W-1];
    logic [SUM_W-1:0] rm_reg [0:Q_W-1];
    logic [Q_W-1:0]   qt_reg [0:Q_W-1];

    for (genvar j = 0; j < Q_W; j++)
    begin : g_div
        logic [SUM_W-1:0] d_in;
        logic [REM_W-1:0] rem_cur;
        logic [Q_W-1:0]   q_in;
        logic             ge;

        always_comb
        begin
            if (j == 0)
            begin
                d_in    = sd_reg[EXP_TERMS-1];
                rem_cur = REM_W'(ONE30);
                q_in    = '0;
            end
            else
            begin
                d_in    = dv_reg[(j == 0) ? 0 : j-1];
                rem_cur = {rm_reg[(j == 0) ? 0 : j-1], 1'b0};
                q_in    = qt_reg[(j == 0) ? 0 : j-1];
            end
            ge = rem_cur >= REM_W'(d_in);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_reg[j] <= d_in;
                if (ge)
                begin
                    rm_reg[j] <= SUM_W'(rem_cur - REM_W'(d_in));
                    qt_reg[j] <= q_in | (Q_W'(1) << (Q_W - 1 - j));
                end
                else
                begin
                    rm_reg[j] <= SUM_W'(rem_cur);
                    qt_reg[j] <= q_in;
                end
            end
        end
    end

    // scale by the law's coefficient
    logic [POW_W-1:0] pw_reg;
    logic [63:0]      pw_prod;

    assign pw_prod = 64'(c_coef) * 64'(qt_reg[Q_W-1]);

    always_ff @(posedge clk)
    begin
        if (en)
            pw_reg <= pw_prod[30 +: POW_W];
    end

    assign pow_val = pw_reg;

endmodule

// ===== src/ctr_level.sv =====
// ----------------------------------------------------------------------------
// ctr_level
// clamps a Q16 channel value on the 0..255 scale and rounds it to a level
// ----------------------------------------------------------------------------
module ctr_level import ctr_pkg::*;
#(
    parameter int LEVEL_BITS = 8
)
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [LAW_W-1:0] value,
    output logic [LEVEL_BITS-1:0]   level
);

    localparam logic [63:0] LEVEL_MAX = (64'd1 << LEVEL_BITS) - 64'd1;

    logic [23:0]           w_reg;
    logic [LEVEL_BITS-1:0] lvl_reg;
    logic [23:0]           v_clamp;
    logic [63:0]           n_prod;
    logic [23:0]           w_next;
    logic [63:0]           s_prod;

    // clamp, scale to the level range, drop the binary part of the divisor
    always_comb
    begin
        if (value >= $signed({4'd0, V_FULL}))
            v_clamp = V_FULL;
        else
            v_clamp = value[23:0];
        n_prod = 64'(v_clamp) * LEVEL_MAX + 64'(V_HALF);
        if (value <= $signed(LAW_W'(0)))
            w_next = '0;
        else
            w_next = n_prod[16 +: 24];
        s_prod = 64'(w_reg) * LVL_MAG;
    end

    // divide by 255 through a reciprocal
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg   <= w_next;
            lvl_reg <= s_prod[LVL_SH +: LEVEL_BITS];
        end
    end

    assign level = lvl_reg;

endmodule

// ===== src/color_temperature_to_rgb_unit.sv =====
// ----------------------------------------------------------------------------
// color_temperature_to_rgb_unit
// blackbody color temperature to RGB levels, fully pipelined
// ----------------------------------------------------------------------------
// Usage:
//   one transfer on the slave stream carries a temperature in kelvin; it is
//   clamped to 1000..40000 and turned into red, green and blue levels that
//   leave as one transfer on the master stream, in input order.
//   The datapath is 100 register stages deep, and m_tvalid is the valid bit
//   of the last of them.
//   Stages: 1 input stage, 31 log2 stages (normalize, then one squaring per
//   fraction bit), 66 power-law stages (2 exponent stages, 16 series terms
//   at two stages each, 31 stages of bit-serial reciprocal, scaling), 2
//   rounding stages. The power law sets that depth.
//   Throughput is one temperature per cycle while no result is held up by m_tready.
//   All stages advance together; when the receiver holds m_tready low with a
//   result waiting, the whole pipeline holds and s_tready drops, so nothing
//   is lost or repeated.
//   Reset clears every valid bit; the unit is ready in the first cycle after.
// ----------------------------------------------------------------------------
module color_temperature_to_rgb_unit import ctr_pkg::*;
#(
    parameter int  LEVEL_BITS = 8,
    localparam int OUT_W      = ((3 * LEVEL_BITS + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [15:0]      s_tdata,   // color_temp
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // red_level, green_level, blue_level, zero pad
);

    logic [TOTAL_LAT-1:0] vld_reg;
    logic                 adv;

    // pipeline moves when the output slot is free or being taken
    assign adv      = !vld_reg[TOTAL_LAT-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[TOTAL_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[TOTAL_LAT-2:0], s_tvalid};
    end

    // input stage: clamp and scale to t = k / 100 in Q16
    logic [15:0]      k_clamp;
    logic [31:0]      t_num;
    logic [63:0]      t_prod;
    logic [X_W-1:0]   t_next;
    ctr_flags_t       flg_next;
    logic [X_W-1:0]   t_reg;
    ctr_flags_t       flg_reg [0:FLG_DEPTH-1];

    always_comb
    begin
        if (s_tdata < K_MIN)
            k_clamp = K_MIN;
        else if (s_tdata > K_MAX)
            k_clamp = K_MAX;
        else
            k_clamp = s_tdata;
        t_num          = {k_clamp, 16'd0} + 32'd50;
        t_prod         = 64'(t_num) * T_DIV_MAG;
        t_next         = t_prod[T_DIV_SH +: X_W];
        flg_next.low   = k_clamp <= K_KNEE;
        flg_next.bfull = k_clamp >= K_KNEE;
        flg_next.bzero = k_clamp <= K_BLU_OFF;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg      <= t_next;
            flg_reg[0] <= flg_next;
            for (int i = 1; i < FLG_DEPTH; i++)
                flg_reg[i] <= flg_reg[i-1];
        end
    end

    // log2 of the arguments, shifted by the fit offsets except for green at or below the knee
    logic [X_W-1:0]   x_a;
    logic [X_W-1:0]   x_b;
    logic [LOG_W-1:0] log_a;
    logic [LOG_W-1:0] log_b;

    assign x_a = flg_reg[0].low ? t_reg : t_reg - T_OFS_RG;
    assign x_b = t_reg - T_OFS_B;

    ctr_log2 u_log_a
    (
        .clk     (clk),
        .en      (adv),
        .x       (x_a),
        .log_val (log_a)
    );

    ctr_log2 u_log_b
    (
        .clk     (clk),
        .en      (adv),
        .x       (x_b),
        .log_val (log_b)
    );

    // power laws above the knee
    logic [POW_W-1:0] pow_red;
    logic [POW_W-1:0] pow_grn;

    ctr_pow u_pow_red
    (
        .clk     (clk),
        .en      (adv),
        .log_val (log_a),
        .c_coef  (RED_C_Q16[COEF_W-1:0]),
        .p_coef  (RED_P_Q30[FRAC_W-1:0]),
        .pow_val (pow_red)
    );

    ctr_pow u_pow_grn
    (
        .clk     (clk),
        .en      (adv),
        .log_val (log_a),
        .c_coef  (GRN_C_Q16[COEF_W-1:0]),
        .p_coef  (GRN_P_Q30[FRAC_W-1:0]),
        .pow_val (pow_grn)
    );

    // log laws: natural log, then a*ln - b, then delay to line up with the power laws
    logic [LN_W-1:0]         lna_reg;
    logic [LN_W-1:0]         lnb_reg;
    logic signed [LAW_W-1:0] dg_reg [0:LAW_DLY];
    logic signed [LAW_W-1:0] db_reg [0:LAW_DLY];
    logic [63:0]             lna_prod;
    logic [63:0]             lnb_prod;
    logic [63:0]             ga_prod;
    logic [63:0]             ba_prod;
    logic signed [LAW_W-1:0] vg_next;
    logic signed [LAW_W-1:0] vb_next;

    always_comb
    begin
        lna_prod = 64'(log_a) * LN2_Q30;
        lnb_prod = 64'(log_b) * LN2_Q30;
        ga_prod  = 64'(lna_reg) * 64'(GRN_A_Q16[COEF_W-1:0]);
        ba_prod  = 64'(lnb_reg) * 64'(BLU_A_Q16[COEF_W-1:0]);
        vg_next  = $signed({1'b0, ga_prod[30 +: LAW_W-1]})
                 - $signed(LAW_W'(GRN_B_Q16[COEF_W-1:0]));
        vb_next  = $signed({1'b0, ba_prod[30 +: LAW_W-1]})
                 - $signed(LAW_W'(BLU_B_Q16[COEF_W-1:0]));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lna_reg   <= lna_prod[30 +: LN_W];
            lnb_reg   <= lnb_prod[30 +: LN_W];
            dg_reg[0] <= vg_next;
            db_reg[0] <= vb_next;
            for (int i = 1; i <= LAW_DLY; i++)
            begin
                dg_reg[i] <= dg_reg[i-1];
                db_reg[i] <= db_reg[i-1];
            end
        end
    end

    // pick each channel's law
    ctr_flags_t              flg_out;
    logic signed [LAW_W-1:0] v_red;
    logic signed [LAW_W-1:0] v_grn;
    logic signed [LAW_W-1:0] v_blu;

    always_comb
    begin
        flg_out = flg_reg[FLG_DEPTH-1];
        v_red   = flg_out.low ? $signed(LAW_W'(V_FULL)) : $signed(LAW_W'(pow_red));
        v_grn   = flg_out.low ? dg_reg[LAW_DLY] : $signed(LAW_W'(pow_grn));
        if (flg_out.bfull)
            v_blu = $signed(LAW_W'(V_FULL));
        else if (flg_out.bzero)
            v_blu = '0;
        else
            v_blu = db_reg[LAW_DLY];
    end

    // rounding to output levels
    logic [LEVEL_BITS-1:0] red_level;
    logic [LEVEL_BITS-1:0] green_level;
    logic [LEVEL_BITS-1:0] blue_level;

    ctr_level #(.LEVEL_BITS(LEVEL_BITS)) u_lvl_red
    (
        .clk   (clk),
        .en    (adv),
        .value (v_red),
        .level (red_level)
    );

    ctr_level #(.LEVEL_BITS(LEVEL_BITS)) u_lvl_grn
    (
        .clk   (clk),
        .en    (adv),
        .value (v_grn),
        .level (green_level)
    );

    ctr_level #(.LEVEL_BITS(LEVEL_BITS)) u_lvl_blu
    (
        .clk   (clk),
        .en    (adv),
        .value (v_blu),
        .level (blue_level)
    );

    assign m_tdata = OUT_W'({blue_level, green_level, red_level});

endmodule

// ===== src/ctr_checker.sv =====
// ----------------------------------------------------------------------------
// ctr_checker
// port-level checks of the color temperature unit, bound to the top level
// ----------------------------------------------------------------------------
`include "color_temperature_to_rgb_unit_macros.svh"

module ctr_checker
#(
    parameter int  LEVEL_BITS = 8,
    localparam int OUT_W      = ((3 * LEVEL_BITS + 7) / 8) * 8
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [15:0]      s_tdata,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    localparam logic [LEVEL_BITS-1:0] LVL_FULL = '1;

    logic [LEVEL_BITS-1:0] red_lvl;
    logic [LEVEL_BITS-1:0] blue_lvl;
    logic                  in_xfer;

    assign red_lvl  = m_tdata[LEVEL_BITS-1:0];
    assign blue_lvl = m_tdata[2*LEVEL_BITS +: LEVEL_BITS];
    assign in_xfer  = s_tvalid && s_tready && (s_tdata != 16'd0 || s_tdata == 16'd0);

    // a stalled result stays offered
    `CTR_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    // input side only waits while a result is stalled
    `CTR_ASSERT_IMP(a_ready_rule, 1'b1, s_tready == (!m_tvalid || m_tready), "bad s_tready")

    // red is full at or below the knee and blue at or above it
    `CTR_ASSERT_IMP(a_red_or_blue, m_tvalid, (red_lvl == LVL_FULL) || (blue_lvl == LVL_FULL), "neither red nor blue full")

    // no transfer is accepted while a result is stalled
    `CTR_ASSERT_IMP(a_no_take_on_stall, m_tvalid && !m_tready, !in_xfer, "transfer taken while stalled")

endmodule

bind color_temperature_to_rgb_unit ctr_checker #(.LEVEL_BITS(LEVEL_BITS)) u_ctr_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
